// ===== hdl/vfcm_pkg.sv =====
// Shared types and constants for the voxel face cull mask block.
package vfcm_pkg;

  localparam int COORD_W = 6;
  localparam int NUM_FACES = 6;
  localparam int STEP_W = 3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
  localparam logic [STEP_W-1:0] STEP_PX = 3'd1;
  localparam logic [STEP_W-1:0] STEP_NX = 3'd2;
  localparam logic [STEP_W-1:0] STEP_PY = 3'd3;
  localparam logic [STEP_W-1:0] STEP_NY = 3'd4;
  localparam logic [STEP_W-1:0] STEP_PZ = 3'd5;
  localparam logic [STEP_W-1:0] STEP_NZ = 3'd6;

  typedef struct packed {
    logic              load_base;
    logic [STEP_W-1:0] step;
  } agu_ctl_t;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_CALC = 7'b0000100,
    S_WR   = 7'b0001000,
    S_RD   = 7'b0010000,
    S_DRN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

endpackage

// ===== hdl/vfcm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vfcm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/vfcm_agu.sv =====
// Address unit: linear cell index of a voxel and its six neighbors via one add/sub.
module vfcm_agu #(
  parameter int SIDE = 16
) (
  input  logic                              clk,
  input  vfcm_pkg::agu_ctl_t                ctl,
  input  logic signed [vfcm_pkg::COORD_W-1:0] pos_x,
  input  logic signed [vfcm_pkg::COORD_W-1:0] pos_y,
  input  logic signed [vfcm_pkg::COORD_W-1:0] pos_z,
  output logic [$clog2((SIDE+2)*(SIDE+2)*(SIDE+2))-1:0] addr
);

  localparam int EDGE = SIDE + 2;
  localparam int DEPTH = EDGE * EDGE * EDGE;
  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] OFF_X = AW'(1);
  localparam logic [AW-1:0] OFF_Y = AW'(EDGE);
  localparam logic [AW-1:0] OFF_Z = AW'(EDGE * EDGE);

  logic signed [7:0] x1;
  logic signed [7:0] y1;
  logic signed [7:0] z1;
  logic [AW-1:0]     base_r;
  logic [AW-1:0]     base_nxt;
  logic [AW-1:0]     off;
  logic              sub;

  assign x1 = 8'(pos_x) + 8'sd1;
  assign y1 = 8'(pos_y) + 8'sd1;
  assign z1 = 8'(pos_z) + 8'sd1;

  always_comb begin
    base_nxt = AW'(AW'(z1[6:0]) * OFF_Z) + AW'(AW'(y1[6:0]) * OFF_Y) + AW'(x1[6:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_base) begin
      base_r <= base_nxt;
    end
  end

  always_comb begin
    off = '0;
    sub = 1'b0;
    case (ctl.step)
      vfcm_pkg::STEP_CENTER: begin off = '0;    sub = 1'b0; end
      vfcm_pkg::STEP_PX:     begin off = OFF_X; sub = 1'b0; end
      vfcm_pkg::STEP_NX:     begin off = OFF_X; sub = 1'b1; end
      vfcm_pkg::STEP_PY:     begin off = OFF_Y; sub = 1'b0; end
      vfcm_pkg::STEP_NY:     begin off = OFF_Y; sub = 1'b1; end
      vfcm_pkg::STEP_PZ:     begin off = OFF_Z; sub = 1'b0; end
      vfcm_pkg::STEP_NZ:     begin off = OFF_Z; sub = 1'b1; end
      default:               begin off = '0;    sub = 1'b0; end
    endcase
  end

  assign addr = sub ? (base_r - off) : (base_r + off);

endmodule

// ===== hdl/voxel_face_cull_mask.sv =====
// Top level: voxel face cull mask with halo opacity store and read sequencer.
// Query: accept, a calc state to form the cell index, seven reads of the bit RAM
// (center and six neighbors, one per cycle through the shared address unit), a drain
// state and a result state that waits on out_ready; no new item is taken before idle.
// Write: calc, then a RAM write, dropped after calc outside the store; a query outside
// the interior skips the reads. Reset clears all (SIDE+2)^3 cells (5832 at SIDE=16).
module voxel_face_cull_mask #(
  parameter int SIDE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic signed [vfcm_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [vfcm_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [vfcm_pkg::COORD_W-1:0] in_pos_z,
  input  logic                                in_opaque_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [vfcm_pkg::NUM_FACES-1:0]      out_face_mask,
  output logic                                out_voxel_opaque,
  output logic                                out_bad_coord
);

  localparam int EDGE = SIDE + 2;
  localparam int DEPTH = EDGE * EDGE * EDGE;
  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_CELL = AW'(DEPTH - 1);
  localparam logic signed [7:0] SIDE_S = 8'(SIDE);

  vfcm_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic             cmd_r, opq_r, store_ok_r, inter_ok_r;
  logic signed [vfcm_pkg::COORD_W-1:0] px_r, py_r, pz_r;
  logic [vfcm_pkg::STEP_W-1:0] step_r, step_nxt;
  logic             pend_r, pend_nxt;
  logic [vfcm_pkg::STEP_W-1:0] pidx_r;
  logic             ctr_r;
  logic [vfcm_pkg::NUM_FACES-1:0] nbr_r;
  logic             bad_r, bad_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [vfcm_pkg::NUM_FACES-1:0] out_mask_r;
  logic             out_opq_r, out_bad_r, out_load;

  logic signed [7:0] sx, sy, sz;
  logic             acc, store_ok, inter_ok;

  vfcm_pkg::agu_ctl_t agu_ctl;
  logic [AW-1:0]      agu_addr;
  logic               ram_we, ram_wd, ram_rd;
  logic [AW-1:0]      ram_wa;

  assign sx = 8'(in_pos_x);
  assign sy = 8'(in_pos_y);
  assign sz = 8'(in_pos_z);
  assign store_ok = (sx >= -8'sd1) && (sx <= SIDE_S) && (sy >= -8'sd1) && (sy <= SIDE_S)
                 && (sz >= -8'sd1) && (sz <= SIDE_S);
  assign inter_ok = (sx >= 8'sd0) && (sx < SIDE_S) && (sy >= 8'sd0) && (sy < SIDE_S)
                 && (sz >= 8'sd0) && (sz < SIDE_S);

  assign in_ready = (state_r == vfcm_pkg::S_IDLE);
  assign acc = in_valid && in_ready;

  assign agu_ctl.load_base = (state_r == vfcm_pkg::S_CALC);
  assign agu_ctl.step = (state_r == vfcm_pkg::S_RD) ? step_r : vfcm_pkg::STEP_CENTER;

  vfcm_agu #(.SIDE(SIDE)) u_agu (
    .clk   (clk),
    .ctl   (agu_ctl),
    .pos_x (px_r),
    .pos_y (py_r),
    .pos_z (pz_r),
    .addr  (agu_addr)
  );

  assign ram_we = (state_r == vfcm_pkg::S_CLR) || (state_r == vfcm_pkg::S_WR);
  assign ram_wa = (state_r == vfcm_pkg::S_CLR) ? clr_cnt_r : agu_addr;
  assign ram_wd = (state_r == vfcm_pkg::S_CLR) ? 1'b0 : opq_r;

  vfcm_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (agu_addr),
    .rd_data (ram_rd)
  );

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    step_nxt    = step_r;
    pend_nxt    = 1'b0;
    bad_nxt     = bad_r;
    out_load    = 1'b0;
    case (state_r)
      vfcm_pkg::S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_CELL) begin
          state_nxt = vfcm_pkg::S_IDLE;
        end
      end
      vfcm_pkg::S_IDLE: begin
        if (acc) begin
          state_nxt = vfcm_pkg::S_CALC;
        end
      end
      vfcm_pkg::S_CALC: begin
        step_nxt = vfcm_pkg::STEP_CENTER;
        bad_nxt  = !inter_ok_r;
        if (cmd_r == vfcm_pkg::CMD_WRITE) begin
          state_nxt = store_ok_r ? vfcm_pkg::S_WR : vfcm_pkg::S_IDLE;
        end else begin
          state_nxt = inter_ok_r ? vfcm_pkg::S_RD : vfcm_pkg::S_DONE;
        end
      end
      vfcm_pkg::S_WR: begin
        state_nxt = vfcm_pkg::S_IDLE;
      end
      vfcm_pkg::S_RD: begin
        pend_nxt = 1'b1;
        step_nxt = step_r + 3'd1;
        if (step_r == vfcm_pkg::STEP_NZ) begin
          state_nxt = vfcm_pkg::S_DRN;
        end
      end
      vfcm_pkg::S_DRN: begin
        state_nxt = vfcm_pkg::S_DONE;
      end
      vfcm_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = vfcm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = vfcm_pkg::S_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vfcm_pkg::S_CLR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r      <= in_cmd;
      px_r       <= in_pos_x;
      py_r       <= in_pos_y;
      pz_r       <= in_pos_z;
      opq_r      <= in_opaque_in;
      store_ok_r <= store_ok;
      inter_ok_r <= inter_ok;
    end
    step_r <= step_nxt;
    bad_r  <= bad_nxt;
    pidx_r <= step_r;
    if (pend_r) begin
      case (pidx_r)
        vfcm_pkg::STEP_CENTER: ctr_r <= ram_rd;
        vfcm_pkg::STEP_PX:     nbr_r[0] <= ram_rd;
        vfcm_pkg::STEP_NX:     nbr_r[1] <= ram_rd;
        vfcm_pkg::STEP_PY:     nbr_r[2] <= ram_rd;
        vfcm_pkg::STEP_NY:     nbr_r[3] <= ram_rd;
        vfcm_pkg::STEP_PZ:     nbr_r[4] <= ram_rd;
        vfcm_pkg::STEP_NZ:     nbr_r[5] <= ram_rd;
        default:               ctr_r <= ctr_r;
      endcase
    end
    if (out_load) begin
      out_bad_r  <= bad_r;
      out_opq_r  <= !bad_r && ctr_r;
      out_mask_r <= (!bad_r && ctr_r) ? nbr_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_face_mask    = out_mask_r;
  assign out_voxel_opaque = out_opq_r;
  assign out_bad_coord    = out_bad_r;

  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == vfcm_pkg::S_DONE))
    else $error("result raised outside result state");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> (out_mask_r == '0) && !out_opq_r)
    else $error("bad coordinate result carries mask or opacity");

  a_mask_needs_opq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_mask_r != '0) |-> out_opq_r)
    else $error("mask set for transparent voxel");

  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == vfcm_pkg::S_CLR) && (state_r == vfcm_pkg::S_IDLE)
      |-> $past(clr_cnt_r) == LAST_CELL)
    else $error("clear pass ended early");

  a_pend_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(state_r == vfcm_pkg::S_RD))
    else $error("read data captured without issued read");

endmodule
